// ===== sv/dfe_pkg.sv =====
package dfe_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int OUT_COLS    = 4;
  localparam int VALUE_W     = 11;
  localparam int FRAME_W     = 16;
  localparam int SLOT_COUNT  = 17;
  localparam int SLOT_W      = 5;
  localparam int COUNT_W     = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0]  THROTTLE_LIMIT = 11'h7FF;
  localparam logic [SLOT_W-1:0]   LAST_SLOT      = 5'(SLOT_COUNT - 1);
  localparam logic [COUNT_W-1:0]  ONE_HIGH_RESET  = 9'd213;
  localparam logic [COUNT_W-1:0]  ZERO_HIGH_RESET = 9'd106;

  typedef enum logic [1:0] {
    CMD_THROTTLE = 2'd0,
    CMD_CODE     = 2'd1,
    CMD_EMIT     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ONE_HIGH  = 2'd0,
    CFG_ZERO_HIGH = 2'd1,
    CFG_TELEMETRY = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef frame_t [OUT_COLS-1:0] frame_set_t;

  // queue handshake between the front and back halves
  typedef struct packed {
    logic       valid;
    frame_set_t frames;
  } job_t;

  // value[10:0], telemetry bit, then XOR of the three nibbles above
  function automatic frame_t frame_of(input logic [VALUE_W-1:0] v, input logic tlm);
    logic [11:0] upper;
    logic [3:0]  crc;
    upper = {v, tlm};
    crc   = upper[3:0] ^ upper[7:4] ^ upper[11:8];
    return {upper, crc};
  endfunction

endpackage

// ===== sv/dfe_front.sv =====
module dfe_front
  import dfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         cmd,
  input  logic [2:0]         motor,
  input  logic [15:0]        value,
  input  logic               telemetry_request,
  output job_t               push
);

  logic [VALUE_W-1:0] motor_values [MOTOR_COUNT];
  logic               motor_ok;
  logic [VALUE_W-1:0] wr_value;
  frame_set_t         frames;

  assign motor_ok = {1'b0, motor} < 4'(MOTOR_COUNT);

  always_comb begin
    if (cmd == CMD_THROTTLE) begin
      wr_value = (|value[15:VALUE_W]) ? THROTTLE_LIMIT : value[VALUE_W-1:0];
    end else begin
      wr_value = value[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_values[i] <= '0;
      end
    end else if (accept && motor_ok && (cmd == CMD_THROTTLE || cmd == CMD_CODE)) begin
      motor_values[motor[MIDX_W-1:0]] <= wr_value;
    end
  end

  // only the first four motors have output columns
  for (genvar c = 0; c < OUT_COLS; c++) begin : g_col
    if (c < MOTOR_COUNT) begin : g_live
      assign frames[c] = frame_of(motor_values[c], telemetry_request);
    end else begin : g_empty
      assign frames[c] = '0;
    end
  end

  assign push.valid  = accept && (cmd == CMD_EMIT);
  assign push.frames = frames;

endmodule

// ===== sv/dfe_queue.sv =====
module dfe_queue
  import dfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       push,
  input  logic       pop,
  output job_t       head,
  output logic       full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_set_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid  = count != '0;
  assign head.frames = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.frames;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== sv/dfe_back.sv =====
module dfe_back
  import dfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  job_t               head,
  output logic               pop,
  input  logic [COUNT_W-1:0] one_high_count,
  input  logic [COUNT_W-1:0] zero_high_count,
  output logic               slot_valid,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [COUNT_W-1:0] duty [OUT_COLS],
  output logic               last_slot
);

  logic              active;
  logic [SLOT_W-1:0] slot;
  frame_set_t        shift;
  logic              is_last;

  assign pop     = !active && head.valid;
  assign is_last = slot == LAST_SLOT;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      slot_valid <= 1'b0;
      slot       <= '0;
    end else begin
      slot_valid <= active;
      if (active) begin
        slot_index <= slot;
        last_slot  <= is_last;
        for (int c = 0; c < OUT_COLS; c++) begin
          if (is_last || c >= MOTOR_COUNT) begin
            duty[c] <= '0;
          end else begin
            duty[c] <= shift[c][FRAME_W-1] ? one_high_count : zero_high_count;
          end
          shift[c] <= {shift[c][FRAME_W-2:0], 1'b0};
        end
        if (is_last) begin
          active <= 1'b0;
        end else begin
          slot <= slot + 1'b1;
        end
      end else if (head.valid) begin
        shift  <= head.frames;
        slot   <= '0;
        active <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/dshot_frame_encoder.sv =====
// DShot frame encoder for four motor outputs. A throttle or command write
// (cmd 0/1) is registered when accepted and seen by later emits. An emit
// (cmd 2) snapshots all motor values into a two-entry frame queue; the slot
// sequencer drains it and drives 17 slots on consecutive cycles, slot_valid
// high for each, once the queue entry, the sequencer load and the slot
// outputs are registered. The receiver cannot stall: slots go out
// unconditionally, so it must take one every cycle. Back-to-back frames are
// separated by an idle gap while the sequencer loads the next queue entry.
// busy rises only when the queue holds two pending frames.
module dshot_frame_encoder
  import dfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [2:0]         motor,
  input  logic [15:0]        value,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output logic               slot_valid,
  output logic [4:0]         slot_index,
  output logic [8:0]         duty_motor_one,
  output logic [8:0]         duty_motor_two,
  output logic [8:0]         duty_motor_three,
  output logic [8:0]         duty_motor_four,
  output logic               last_slot
);

  logic [COUNT_W-1:0] one_high_count;
  logic [COUNT_W-1:0] zero_high_count;
  logic               telemetry_request;
  logic               accept;
  logic               full;
  logic               pop;
  job_t               push;
  job_t               head;
  logic [COUNT_W-1:0] duty [OUT_COLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_count    <= ONE_HIGH_RESET;
      zero_high_count   <= ZERO_HIGH_RESET;
      telemetry_request <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ONE_HIGH:  one_high_count    <= cfg_data;
        CFG_ZERO_HIGH: zero_high_count   <= cfg_data;
        CFG_TELEMETRY: telemetry_request <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy   = full;
  assign accept = start && !busy;

  dfe_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .cmd               (cmd),
    .motor             (motor),
    .value             (value),
    .telemetry_request (telemetry_request),
    .push              (push)
  );

  dfe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  dfe_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .one_high_count  (one_high_count),
    .zero_high_count (zero_high_count),
    .slot_valid      (slot_valid),
    .slot_index      (slot_index),
    .duty            (duty),
    .last_slot       (last_slot)
  );

  assign duty_motor_one   = duty[0];
  assign duty_motor_two   = duty[1];
  assign duty_motor_three = duty[2];
  assign duty_motor_four  = duty[3];

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import dfe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;

  typedef struct packed {
    logic [4:0]      idx;
    logic [3:0][8:0] duty;  // [0] is motor one
    logic            last;
  } slot_t;

  class dshot_scoreboard;
    logic [VALUE_W-1:0] motor_val [MOTOR_COUNT];
    logic [COUNT_W-1:0] one_cnt;
    logic [COUNT_W-1:0] zero_cnt;
    logic               tlm;
    slot_t              pending [$];
    int errors;
    int shown;
    int writes;
    int ignored;
    int frames;
    int slots;
    int cfg_writes;

    function new();
      for (int k = 0; k < MOTOR_COUNT; k++) motor_val[k] = '0;
      one_cnt  = ONE_HIGH_RESET;
      zero_cnt = ZERO_HIGH_RESET;
      tlm      = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [8:0] d);
      cfg_writes++;
      case (idx)
        CFG_ONE_HIGH:  one_cnt  = d;
        CFG_ZERO_HIGH: zero_cnt = d;
        CFG_TELEMETRY: tlm      = d[0];
        default: ;
      endcase
    endfunction

    function void note_item(cmd_t c, logic [2:0] m, logic [15:0] v);
      logic [FRAME_W-1:0] frm [4];
      logic [11:0] up;
      logic [3:0]  crc;
      slot_t s;
      case (c)
        CMD_THROTTLE, CMD_CODE: begin
          if (m < MOTOR_COUNT) begin
            if (c == CMD_THROTTLE && v > 16'(THROTTLE_LIMIT))
              motor_val[m] = THROTTLE_LIMIT;
            else
              motor_val[m] = v[VALUE_W-1:0];
            writes++;
          end else begin
            ignored++;
          end
        end
        CMD_EMIT: begin
          frames++;
          for (int k = 0; k < 4; k++) begin
            frm[k] = '0;
            if (k < MOTOR_COUNT) begin
              up  = {motor_val[k], tlm};
              crc = '0;
              for (int n = 0; n < 3; n++) crc ^= 4'(up >> (4 * n));
              frm[k] = {up, crc};
            end
          end
          for (int b = 0; b < SLOT_COUNT; b++) begin
            s.idx  = 5'(b);
            s.last = (b == SLOT_COUNT - 1);
            for (int k = 0; k < 4; k++) begin
              if (s.last || k >= MOTOR_COUNT) s.duty[k] = '0;
              else s.duty[k] = frm[k][FRAME_W-1-b] ? one_cnt : zero_cnt;
            end
            pending.push_back(s);
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void field_cmp(string name, int idx, int exp_v, int got_v);
      if (exp_v != got_v) begin
        errors++;
        if (shown < 10)
          $display("MISMATCH slot %0d %s: expected %0d, got %0d", idx, name, exp_v, got_v);
        shown++;
      end
    endfunction

    function void check_slot(slot_t got);
      slot_t exp_s;
      string names [4] = '{"duty_motor_one", "duty_motor_two", "duty_motor_three",
                           "duty_motor_four"};
      slots++;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) $display("UNEXPECTED slot %0d with no frame pending", got.idx);
        shown++;
      end else begin
        exp_s = pending.pop_front();
        field_cmp("slot_index", exp_s.idx, exp_s.idx, got.idx);
        for (int k = 0; k < 4; k++)
          field_cmp(names[k], exp_s.idx, exp_s.duty[k], got.duty[k]);
        field_cmp("last_slot", exp_s.idx, exp_s.last, got.last);
      end
    endfunction

    function void finish_check();
      if (pending.size() != 0) begin
        errors++;
        $display("MISSING %0d slots never came out", pending.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [2:0]  motor;
  logic [15:0] value;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        slot_valid;
  logic [4:0]  slot_index;
  logic [8:0]  duty_motor_one;
  logic [8:0]  duty_motor_two;
  logic [8:0]  duty_motor_three;
  logic [8:0]  duty_motor_four;
  logic        last_slot;

  dshot_scoreboard sb = new();
  int cycles;
  int stalls;
  int sent;
  int idle_pct;

  dshot_frame_encoder u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .motor            (motor),
    .value            (value),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .slot_valid       (slot_valid),
    .slot_index       (slot_index),
    .duty_motor_one   (duty_motor_one),
    .duty_motor_two   (duty_motor_two),
    .duty_motor_three (duty_motor_three),
    .duty_motor_four  (duty_motor_four),
    .last_slot        (last_slot)
  );

  always #5 clk = ~clk;

  // sample everything on the rising edge, before the block's updates land
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (slot_valid)
        sb.check_slot('{slot_index, {duty_motor_four, duty_motor_three, duty_motor_two,
                                     duty_motor_one}, last_slot});
      if (start && busy) stalls++;
      if (start && !busy) sb.note_item(cmd_t'(cmd), motor, value);
      if (cfg_write) sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // leaves start high so a following transaction can go back to back
  task automatic send_item(cmd_t c, logic [2:0] m, logic [15:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd   = c;
    motor = m;
    value = v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!(c == CMD_NONE || (c != CMD_EMIT && m >= MOTOR_COUNT))) sent++;
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [8:0] d);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(negedge clk);
  endtask

  task automatic set_config(logic [8:0] one_c, logic [8:0] zero_c, logic t);
    wait_drain();
    write_reg(CFG_ONE_HIGH, one_c);
    write_reg(CFG_ZERO_HIGH, zero_c);
    write_reg(CFG_TELEMETRY, {8'($urandom), t});
    cfg_write = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(2040, 2056));   // around the throttle clamp
      2: return 16'($urandom_range(0, 31));
      default: return 16'($urandom_range(0, 2047));
    endcase
  endfunction

  // mostly writes followed by an emit; the rest is unconstrained noise
  task automatic run_phase(int n);
    int target;
    int nw;
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        nw = $urandom_range(1, 4);
        repeat (nw)
          send_item($urandom_range(0, 1) ? CMD_CODE : CMD_THROTTLE,
                    ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3)),
                    pick_value());
        send_item(CMD_EMIT, 3'($urandom), 16'($urandom));
      end else begin
        send_item(cmd_t'($urandom_range(0, 3)), 3'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = CMD_THROTTLE;
    motor     = '0;
    value     = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_ONE_HIGH;
    cfg_data  = '0;
    idle_pct  = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: reset values, clamp edges, code masking, ignored writes
    send_item(CMD_EMIT, 3'd0, 16'h0000);
    send_item(CMD_THROTTLE, 3'd0, 16'd0);
    send_item(CMD_THROTTLE, 3'd1, 16'd2047);
    send_item(CMD_THROTTLE, 3'd2, 16'd2048);
    send_item(CMD_THROTTLE, 3'd3, 16'hFFFF);
    send_item(CMD_EMIT, 3'd7, 16'hFFFF);
    send_item(CMD_CODE, 3'd0, 16'hFFFF);
    send_item(CMD_CODE, 3'd1, 16'h0800);
    send_item(CMD_CODE, 3'd2, 16'h0155);
    send_item(CMD_CODE, 3'd3, 16'h02AA);
    send_item(CMD_THROTTLE, 3'd4, 16'd1234);
    send_item(CMD_CODE, 3'd7, 16'h5555);
    send_item(CMD_NONE, 3'd0, 16'hFFFF);
    // back to back emits fill the frame queue
    send_item(CMD_EMIT, 3'd0, 16'h0000);
    send_item(CMD_EMIT, 3'd0, 16'h0000);
    send_item(CMD_EMIT, 3'd0, 16'h0000);
    send_item(CMD_CODE, 3'd3, 16'h0000);
    send_item(CMD_THROTTLE, 3'd0, 16'd1);
    send_item(CMD_EMIT, 3'd5, 16'h1234);

    idle_pct = 33;
    set_config(9'd0, 9'd283, 1'b1);
    run_phase(40);
    set_config(9'd283, 9'd0, 1'b0);
    run_phase(40);
    set_config(9'd511, 9'd1, 1'b1);
    run_phase(20);
    wait_drain();  // hold off the sender until every frame is out
    run_phase(20);
    set_config(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 1'($urandom));
    write_reg(CFG_NONE, 9'($urandom));
    cfg_write = 1'b0;
    run_phase(40);
    set_config(9'($urandom_range(0, 283)), 9'($urandom_range(0, 283)), 1'($urandom));
    idle_pct = 0;
    run_phase(45);
    wait_drain();

    sb.finish_check();
    $display("Covered %0d motor writes, %0d ignored transactions, %0d register writes",
             sb.writes, sb.ignored, sb.cfg_writes);
    $display("Checked %0d frames as %0d slots; sender held off by busy %0d cycles",
             sb.frames, sb.slots, stalls);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
